// ----- rtl/tvp_pkg.sv -----
// Shared types and constants of the trapezoid velocity profile block.
// No dependencies; used by every module in rtl/.
package tvp_pkg;

    localparam int unsigned Q_SHIFT   = 16;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIV_W     = 64;
    localparam int unsigned DIV_LAT   = DIV_W;
    localparam int unsigned SQRT_LAT  = DIV_W / 2;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] PEAK_SPEED_RESET = 32'h0001_0000;
    localparam logic [WORD_W-1:0] ACCEL_RATE_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [31:0] elapsed_time;
        logic [31:0] move_distance;
    } tvp_in_t;

    typedef struct packed {
        logic signed [31:0] speed_command;
        logic [31:0]        profile_end_time;
        logic               finished;
    } tvp_out_t;

endpackage

// ----- rtl/tvp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage (64-bit / 32-bit).
// Depends on tvp_pkg.
module tvp_div
    import tvp_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [DIV_W-1:0]  num,
    input  logic [WORD_W-1:0] den,
    output logic [DIV_W-1:0]  quo
);

    logic [WORD_W-1:0] rem_reg [DIV_LAT];
    logic [DIV_W-1:0]  nq_reg  [DIV_LAT];
    logic [WORD_W-1:0] den_reg [DIV_LAT];

    genvar k;
    generate
        for (k = 0; k < DIV_LAT; k++) begin : g_stage
            logic [WORD_W-1:0] rem_in;
            logic [DIV_W-1:0]  nq_in;
            logic [WORD_W-1:0] den_in;
            logic [WORD_W:0]   rs;
            logic [WORD_W:0]   diff;
            logic              ge;
            logic [WORD_W-1:0] rem_next;
            logic [DIV_W-1:0]  nq_next;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign nq_in  = nq_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // Shift in the next numerator bit and try to subtract
            assign rs       = {rem_in, nq_in[DIV_W-1]};
            assign ge       = (rs >= {1'b0, den_in});
            assign diff     = rs - {1'b0, den_in};
            assign rem_next = ge ? diff[WORD_W-1:0] : rs[WORD_W-1:0];
            assign nq_next  = {nq_in[DIV_W-2:0], ge};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    nq_reg[k]  <= nq_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DIV_LAT-1];

endmodule

// ----- rtl/tvp_isqrt.sv -----
// Pipelined integer square root, one root bit per stage (64-bit radicand).
// Depends on tvp_pkg.
module tvp_isqrt
    import tvp_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [DIV_W-1:0]  radicand,
    output logic [WORD_W-1:0] root
);

    localparam int unsigned REM_W = WORD_W + 2;

    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [WORD_W-1:0] root_reg [SQRT_LAT];
    logic [DIV_W-1:0]  n_reg    [SQRT_LAT];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_stage
            logic [REM_W-1:0]  rem_in;
            logic [WORD_W-1:0] root_in;
            logic [DIV_W-1:0]  n_in;
            logic [REM_W+1:0]  rs;
            logic [REM_W+1:0]  trial;
            logic [REM_W+1:0]  diff;
            logic              ge;
            logic [REM_W-1:0]  rem_next;
            logic [WORD_W-1:0] root_next;
            logic [DIV_W-1:0]  n_next;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign n_in    = radicand;
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign n_in    = n_reg[k-1];
            end

            // Bring down two radicand bits and test the trial divisor 4r+1
            assign rs        = {rem_in, n_in[DIV_W-1:DIV_W-2]};
            assign trial     = {2'b00, root_in, 2'b01};
            assign ge        = (rs >= trial);
            assign diff      = rs - trial;
            assign rem_next  = ge ? diff[REM_W-1:0] : rs[REM_W-1:0];
            assign root_next = {root_in[WORD_W-2:0], ge};
            assign n_next    = {n_in[DIV_W-3:0], 2'b00};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    n_reg[k]    <= n_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_LAT-1];

endmodule

// ----- rtl/trapezoid_velocity_profile.sv -----
// Top level of the trapezoid velocity profile generator.
// Depends on tvp_pkg, tvp_div and tvp_isqrt.
//
// Takes one (elapsed_time, move_distance) beat per clock and returns one
// result beat per input, in order. Each beat passes through 100 register
// stages: the 64-stage dividers (one quotient bit per stage) followed
// by the 32-stage square root of the triangle peak time, plus an input
// stage and three stages for the compare, multiply and saturate steps.
// A stall on the result side holds the whole pipeline; throughput is
// one beat per cycle otherwise.
// peak_speed and accel_rate are written through the cfg port (always
// ready) and must only change while no beat is in flight.
module trapezoid_velocity_profile
    import tvp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tvp_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tvp_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_CRUISE = 2'd1;
    localparam logic [1:0] MODE_DOWN   = 2'd2;

    typedef struct packed {
        logic        valid;
        logic        tri_shape;
        logic [31:0] t;
        logic [31:0] a;
        logic [31:0] v;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [47:0] t1;
        logic [47:0] t2;
    } sq_side_t;

    logic        adv;
    logic [31:0] peak_speed_reg;
    logic [31:0] accel_rate_reg;
    logic [31:0] v_eff;
    logic [31:0] a_eff;

    // Write configuration registers; unknown indices are dropped
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_speed_reg <= PEAK_SPEED_RESET;
            accel_rate_reg <= ACCEL_RATE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_PEAK_SPEED) begin
                peak_speed_reg <= cfg_data;
            end else if (cfg_index == REG_ACCEL_RATE) begin
                accel_rate_reg <= cfg_data;
            end
        end
    end

    // A zero register acts as one
    assign v_eff = (peak_speed_reg == '0) ? 32'd1 : peak_speed_reg;
    assign a_eff = (accel_rate_reg == '0) ? 32'd1 : accel_rate_reg;

    logic        out_valid_reg;
    tvp_out_t    out_reg;

    // Advance the whole pipeline unless the result beat is stalled
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // Input stage: register the beat and the shape products
    logic        p0_valid_reg;
    logic [31:0] p0_t_reg, p0_d_reg, p0_a_reg, p0_v_reg;
    logic [63:0] p0_da_reg, p0_vv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (adv) begin
            p0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_t_reg  <= s_data.elapsed_time;
            p0_d_reg  <= s_data.move_distance;
            p0_a_reg  <= a_eff;
            p0_v_reg  <= v_eff;
            p0_da_reg <= 64'(s_data.move_distance) * 64'(a_eff);
            p0_vv_reg <= 64'(v_eff) * 64'(v_eff);
        end
    end

    // Dividers: d/a for the triangle, v/a and d/v for the trapezoid
    logic [DIV_W-1:0] q_tri, q_t1, q_t2;

    tvp_div u_div_tri (
        .aclk (aclk),
        .en   (adv),
        .num  ({p0_d_reg, 32'd0}),
        .den  (p0_a_reg),
        .quo  (q_tri)
    );

    tvp_div u_div_t1 (
        .aclk (aclk),
        .en   (adv),
        .num  ({16'd0, p0_v_reg, 16'd0}),
        .den  (p0_a_reg),
        .quo  (q_t1)
    );

    tvp_div u_div_t2 (
        .aclk (aclk),
        .en   (adv),
        .num  ({16'd0, p0_d_reg, 16'd0}),
        .den  (p0_v_reg),
        .quo  (q_t2)
    );

    // Carry the valid bit and side data alongside the dividers
    side_t side_reg [DIV_LAT];
    side_t side_in;

    assign side_in.valid     = p0_valid_reg;
    assign side_in.tri_shape = (p0_da_reg < p0_vv_reg);
    assign side_in.t         = p0_t_reg;
    assign side_in.a         = p0_a_reg;
    assign side_in.v         = p0_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (adv) begin
            side_reg[0].valid <= side_in.valid;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i].valid <= side_reg[i-1].valid;
            end
        end
        if (adv) begin
            side_reg[0].tri_shape <= side_in.tri_shape;
            side_reg[0].t         <= side_in.t;
            side_reg[0].a         <= side_in.a;
            side_reg[0].v         <= side_in.v;
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i].tri_shape <= side_reg[i-1].tri_shape;
                side_reg[i].t         <= side_reg[i-1].t;
                side_reg[i].a         <= side_reg[i-1].a;
                side_reg[i].v         <= side_reg[i-1].v;
            end
        end
    end

    // Square root of d/a gives the triangle peak time
    logic [31:0] tp;

    tvp_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (q_tri),
        .root     (tp)
    );

    sq_side_t sq_reg [SQRT_LAT];
    sq_side_t sq_in;

    assign sq_in.side = side_reg[DIV_LAT-1];
    assign sq_in.t1   = q_t1[47:0];
    assign sq_in.t2   = q_t2[47:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQRT_LAT; i++) begin
                sq_reg[i].side.valid <= 1'b0;
            end
        end else if (adv) begin
            sq_reg[0].side.valid <= sq_in.side.valid;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sq_reg[i].side.valid <= sq_reg[i-1].side.valid;
            end
        end
        if (adv) begin
            sq_reg[0].side.tri_shape <= sq_in.side.tri_shape;
            sq_reg[0].side.t         <= sq_in.side.t;
            sq_reg[0].side.a         <= sq_in.side.a;
            sq_reg[0].side.v         <= sq_in.side.v;
            sq_reg[0].t1             <= sq_in.t1;
            sq_reg[0].t2             <= sq_in.t2;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sq_reg[i].side.tri_shape <= sq_reg[i-1].side.tri_shape;
                sq_reg[i].side.t         <= sq_reg[i-1].side.t;
                sq_reg[i].side.a         <= sq_reg[i-1].side.a;
                sq_reg[i].side.v         <= sq_reg[i-1].side.v;
                sq_reg[i].t1             <= sq_reg[i-1].t1;
                sq_reg[i].t2             <= sq_reg[i-1].t2;
            end
        end
    end

    // Phase stage: pick ramp up, cruise or ramp down and the end time
    sq_side_t    sqo;
    logic        e_before;
    logic        e_cruise;
    logic [1:0]  e_mode_next;
    logic [31:0] e_diff_next;
    logic [31:0] e_x1_next;
    logic [31:0] e_end_next;
    logic [32:0] e_end_tri;
    logic [48:0] e_end_trap;

    assign sqo        = sq_reg[SQRT_LAT-1];
    assign e_end_tri  = {tp, 1'b0};
    assign e_end_trap = {1'b0, sqo.t1} + {1'b0, sqo.t2};
    assign e_cruise   = ({16'd0, sqo.side.t} <= sqo.t2);

    always_comb begin
        if (sqo.side.tri_shape) begin
            e_before    = (sqo.side.t < tp);
            e_diff_next = sqo.side.t - tp;
            e_end_next  = e_end_tri[32] ? '1 : e_end_tri[31:0];
        end else begin
            e_before    = ({16'd0, sqo.side.t} < sqo.t1);
            e_diff_next = sqo.side.t - sqo.t2[31:0];
            e_end_next  = (e_end_trap[48:32] != '0) ? '1 : e_end_trap[31:0];
        end
        if (e_before) begin
            e_mode_next = MODE_UP;
        end else if (!sqo.side.tri_shape && e_cruise) begin
            e_mode_next = MODE_CRUISE;
        end else begin
            e_mode_next = MODE_DOWN;
        end
        e_x1_next = (e_mode_next == MODE_UP) ? sqo.side.t : tp;
    end

    logic        e_valid_reg;
    logic [1:0]  e_mode_reg;
    logic        e_tri_reg;
    logic [31:0] e_t_reg, e_a_reg, e_v_reg, e_x1_reg, e_diff_reg, e_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= sqo.side.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_mode_reg <= e_mode_next;
            e_tri_reg  <= sqo.side.tri_shape;
            e_t_reg    <= sqo.side.t;
            e_a_reg    <= sqo.side.a;
            e_v_reg    <= sqo.side.v;
            e_x1_reg   <= e_x1_next;
            e_diff_reg <= e_diff_next;
            e_end_reg  <= e_end_next;
        end
    end

    // Multiply stage: a*x1 and a*diff, both scaled back by 2^16
    logic [63:0] f_prod1, f_prod2;
    assign f_prod1 = 64'(e_a_reg) * 64'(e_x1_reg);
    assign f_prod2 = 64'(e_a_reg) * 64'(e_diff_reg);

    logic        f_valid_reg;
    logic [1:0]  f_mode_reg;
    logic        f_tri_reg;
    logic        f_fin_reg;
    logic [31:0] f_v_reg, f_end_reg;
    logic [47:0] f_p1_reg, f_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_mode_reg <= e_mode_reg;
            f_tri_reg  <= e_tri_reg;
            f_fin_reg  <= (e_t_reg >= e_end_reg);
            f_v_reg    <= e_v_reg;
            f_end_reg  <= e_end_reg;
            f_p1_reg   <= f_prod1[63:Q_SHIFT];
            f_p2_reg   <= f_prod2[63:Q_SHIFT];
        end
    end

    // Output stage: combine and saturate to the signed 32-bit range
    logic signed [49:0] g_base;
    logic signed [49:0] g_vel;
    logic signed [31:0] g_sat;

    always_comb begin
        g_base = f_tri_reg ? signed'({2'b00, f_p1_reg}) : signed'({18'd0, f_v_reg});
        case (f_mode_reg)
            MODE_UP:     g_vel = signed'({2'b00, f_p1_reg});
            MODE_CRUISE: g_vel = signed'({18'd0, f_v_reg});
            MODE_DOWN:   g_vel = g_base - signed'({2'b00, f_p2_reg});
            default:     g_vel = '0;
        endcase
        if (g_vel > 50'sd2147483647) begin
            g_sat = 32'sh7FFF_FFFF;
        end else if (g_vel < -50'sd2147483648) begin
            g_sat = 32'sh8000_0000;
        end else begin
            g_sat = g_vel[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.speed_command    <= g_sat;
            out_reg.profile_end_time <= f_end_reg;
            out_reg.finished         <= f_fin_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Valid bits move one stage per advance and hold on a stall
    a_valid_moves : assert property (@(posedge aclk) disable iff (!aresetn)
        adv && f_valid_reg |=> out_valid_reg)
        else $error("result valid lost between multiply and output stage");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(e_valid_reg) && $stable(f_valid_reg) && $stable(p0_valid_reg))
        else $error("pipeline valid bits changed during a stall");

    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg && !p0_valid_reg)
        else $error("pipeline not empty after reset");

    a_cruise_trap : assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg && e_tri_reg |-> e_mode_reg != MODE_CRUISE)
        else $error("triangular profile selected the cruise phase");

endmodule
